[hdl/flm_pkg.sv]
// Shared types and codes for the queued lock manager.
`default_nettype none

package flm_pkg;

    // Request action codes; codes above ACT_UNKNOWN are handled as unknown
    typedef enum logic [2:0] {
        ACT_READ       = 3'd0,
        ACT_UPDATE     = 3'd1,
        ACT_LOCK       = 3'd2,
        ACT_RELEASE    = 3'd3,
        ACT_DISCONNECT = 3'd4,
        ACT_UNKNOWN    = 3'd5
    } action_t;

    // Reply kinds
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_UPD_OK = 2'd1,
        KIND_GRANT  = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    // Error codes carried in the reply data
    localparam logic [31:0] ERR_NOT_HOLDER = 32'd0;
    localparam logic [31:0] ERR_PROTOCOL   = 32'd1;
    localparam logic [31:0] ERR_QUEUE_FULL = 32'd2;

    localparam int CLIENT_W = 6;
    localparam int WORD_W   = 32;

    // Commands from the lock logic to the wait queue
    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    // Wait queue status seen by the lock logic
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // One reply word
    typedef struct packed {
        logic [CLIENT_W-1:0] dest;
        kind_t               kind;
        logic [WORD_W-1:0]   data;
    } reply_t;

endpackage

`default_nettype wire

[hdl/flm_ring.sv]
// Wait queue of client ids: ring memory, pointers, count and head prefetch.
`default_nettype none

module flm_ring #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  flm_pkg::ring_cmd_t            cmd,
    input  logic [flm_pkg::CLIENT_W-1:0]  push_id,
    output flm_pkg::ring_stat_t           stat,
    output logic [flm_pkg::CLIENT_W-1:0]  head_id
);
    import flm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CLIENT_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CLIENT_W-1:0] head_id_reg;

    // Pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Memory write at tail
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= push_id;
        end
    end

    // Registered read of the next head entry; a push into the head slot forwards
    always_ff @(posedge clk)
    begin
        if (cmd.push && (tail_reg == head_next))
        begin
            head_id_reg <= push_id;
        end
        else
        begin
            head_id_reg <= mem[head_next];
        end
    end

    assign head_id    = head_id_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg >= FULL_CNT);

endmodule

`default_nettype wire

[hdl/flm_lock.sv]
// Lock state, shared word and request decode producing queue commands and replies.
`default_nettype none

module flm_lock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [2:0]                    action,
    input  logic [flm_pkg::CLIENT_W-1:0]  client_id,
    input  logic [flm_pkg::WORD_W-1:0]    data_in,
    input  flm_pkg::ring_stat_t           ring_stat,
    input  logic [flm_pkg::CLIENT_W-1:0]  head_id,
    output flm_pkg::ring_cmd_t            ring_cmd,
    output logic                          reply_valid,
    output flm_pkg::reply_t               reply
);
    import flm_pkg::*;

    logic [WORD_W-1:0]   word_reg, word_next;
    logic                taken_reg, taken_next;
    logic [CLIENT_W-1:0] holder_reg, holder_next;
    logic                is_holder;
    logic                push_w, pop_w, emit_w;

    assign is_holder = taken_reg && (holder_reg == client_id);

    // Request decode
    always_comb
    begin
        word_next   = word_reg;
        taken_next  = taken_reg;
        holder_next = holder_reg;
        push_w      = 1'b0;
        pop_w       = 1'b0;
        emit_w      = 1'b0;
        reply.dest  = client_id;
        reply.kind  = KIND_READ;
        reply.data  = '0;
        case (action_t'(action))
            ACT_READ:
            begin
                emit_w     = 1'b1;
                reply.data = word_reg;
            end
            ACT_UPDATE:
            begin
                emit_w = 1'b1;
                if (is_holder)
                begin
                    word_next  = data_in;
                    reply.kind = KIND_UPD_OK;
                end
                else
                begin
                    reply.kind = KIND_ERROR;
                    reply.data = ERR_NOT_HOLDER;
                end
            end
            ACT_LOCK:
            begin
                if (!taken_reg)
                begin
                    taken_next  = 1'b1;
                    holder_next = client_id;
                    emit_w      = 1'b1;
                    reply.kind  = KIND_GRANT;
                end
                else if (ring_stat.full)
                begin
                    emit_w     = 1'b1;
                    reply.kind = KIND_ERROR;
                    reply.data = ERR_QUEUE_FULL;
                end
                else
                begin
                    push_w = 1'b1;
                end
            end
            ACT_RELEASE, ACT_DISCONNECT:
            begin
                if (is_holder)
                begin
                    if (ring_stat.empty)
                    begin
                        taken_next  = 1'b0;
                        holder_next = '0;
                    end
                    else
                    begin
                        // hand over to the oldest waiter
                        pop_w       = 1'b1;
                        holder_next = head_id;
                        emit_w      = 1'b1;
                        reply.dest  = head_id;
                        reply.kind  = KIND_GRANT;
                    end
                end
            end
            default:
            begin
                emit_w     = 1'b1;
                reply.kind = KIND_ERROR;
                reply.data = ERR_PROTOCOL;
            end
        endcase
    end

    assign ring_cmd.push = req_valid && push_w;
    assign ring_cmd.pop  = req_valid && pop_w;
    assign reply_valid   = req_valid && emit_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= '0;
            taken_reg  <= 1'b0;
            holder_reg <= '0;
        end
        else if (req_valid)
        begin
            word_reg   <= word_next;
            taken_reg  <= taken_next;
            holder_reg <= holder_next;
        end
    end

endmodule

`default_nettype wire

[hdl/fifo_lock_manager.sv]
// Queued lock manager top level: request register, lock logic, wait queue, reply register.
//
//  channel  direction  handshake            payload
//  request  in         in_valid / in_ready  action, client_id, data_in
//  reply    out        out_valid/out_ready  dest_client, reply_kind, reply_data
//
// One request word per cycle while replies are not stalled; a request passes the
// request register and then the reply register, and some requests give no reply.
// Each request is decided in one pass through the lock logic; the registered
// head read of the wait ring keeps the next waiter ready for back-to-back handovers.
// Reset clears lock state, shared word, queue pointers and valid flags; the
// ring memory itself is not cleared and needs no clearing pass.
// A stalled reply holds the request register, and in_ready drops with it.
`default_nettype none

module fifo_lock_manager #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [5:0]  client_id,
    input  logic [31:0] data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  dest_client,
    output logic [1:0]  reply_kind,
    output logic [31:0] reply_data
);
    import flm_pkg::*;

    logic                in_valid_reg;
    logic [2:0]          action_reg;
    logic [CLIENT_W-1:0] client_reg;
    logic [WORD_W-1:0]   data_reg;

    logic                out_valid_reg;
    reply_t              reply_reg;

    logic                advance;
    logic                reply_valid;
    reply_t              reply;
    ring_cmd_t           ring_cmd;
    ring_stat_t          ring_stat;
    logic [CLIENT_W-1:0] head_id;

    // Request moves on when the reply register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            client_reg <= client_id;
            data_reg   <= data_in;
        end
    end

    flm_lock u_lock (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (advance),
        .action      (action_reg),
        .client_id   (client_reg),
        .data_in     (data_reg),
        .ring_stat   (ring_stat),
        .head_id     (head_id),
        .ring_cmd    (ring_cmd),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

    flm_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .push_id (client_reg),
        .stat    (ring_stat),
        .head_id (head_id)
    );

    // Reply register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= reply_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && reply_valid)
        begin
            reply_reg <= reply;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_client = reply_reg.dest;
    assign reply_kind  = reply_reg.kind;
    assign reply_data  = reply_reg.data;

    // Checks
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_cmd.push && ring_cmd.pop))
        else $error("wait queue pushed and popped in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.pop |-> !ring_stat.empty)
        else $error("pop from empty wait queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.push |-> !ring_stat.full)
        else $error("push into full wait queue");

    a_silent_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !reply_valid) |=> !out_valid)
        else $error("reply register kept a word after a silent request");

endmodule

`default_nettype wire
